FILE: hw/rtl/bitmap_page_allocator_defines.svh
// Assertion helpers used by the allocator datapath.
// Both expect clk and arst_n in the enclosing scope.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/bpa_pkg.sv
package bpa_pkg;

	localparam int MAP_WORDS = 16;
	localparam int WORD_BITS = 32;
	localparam int BIT_W     = 5;
	localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int WCNT_W    = $clog2(MAP_WORDS + 1);
	localparam int CNT_MAX   = MAP_WORDS * WORD_BITS;
	localparam int CNT_W     = $clog2(CNT_MAX + 1);
	localparam int PAGE_W    = 9;
	localparam int FC_W      = 10;
	localparam int FC_MAX    = 1023;
	localparam int TW_W      = 5;
	localparam int OSP_W     = 10;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;
	localparam int TW_RESET  = 16;
	localparam int OSP_RESET = 1;

	localparam logic [WORD_BITS-1:0] ALL_FREE = 32'hFFFF_FFFF;
	localparam logic [WORD_BITS-1:0] ONE_BIT  = 32'h0000_0001;

	// register index, taken from paddr[2]
	localparam logic REG_TOTAL_WORDS = 1'b0;
	localparam logic REG_OS_PAGES    = 1'b1;

	typedef enum logic [1:0] {
		REQ_INIT  = 2'd0,
		REQ_ALLOC = 2'd1,
		REQ_FREE  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_ARD,
		ST_ACHK,
		ST_FRD,
		ST_FCHK,
		ST_POST
	} state_t;

	typedef struct packed {
		logic take;
		logic clr_idx;
		logic inc_idx;
		logic init_wr;
		logic rd_scan;
		logic rd_free;
		logic alloc_hit;
		logic free_set;
		logic res_fail;
		logic res_ok;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic scan_last;
		logic cnt_zero;
		logic words_zero;
		logic word_nz;
		logic free_bad;
		logic out_busy;
	} sts_t;

	function automatic logic [BIT_W-1:0] lsb_idx(input logic [WORD_BITS-1:0] w);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) r = BIT_W'(i);
		end
		return r;
	endfunction

	function automatic logic [FC_W-1:0] sat_fc(input logic [CNT_W-1:0] c);
		logic [31:0] t;
		t = 32'(c);
		return (t > 32'(FC_MAX)) ? FC_W'(FC_MAX) : t[FC_W-1:0];
	endfunction

	function automatic logic [PAGE_W-1:0] page_of(input logic [WIDX_W-1:0] w,
			input logic [BIT_W-1:0] b);
		logic [31:0] t;
		t = (32'(w) << BIT_W) | 32'(b);
		return t[PAGE_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/bpa_ctrl.sv
module bpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     req_type,
	output logic           in_stall,
	input  bpa_pkg::sts_t  sts,
	output bpa_pkg::cmd_t  cmd
);

	bpa_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bpa_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (req_type)
						bpa_pkg::REQ_INIT:  state_nxt = bpa_pkg::ST_INIT;
						bpa_pkg::REQ_ALLOC: state_nxt = (sts.cnt_zero || sts.words_zero) ?
							bpa_pkg::ST_POST : bpa_pkg::ST_ARD;
						bpa_pkg::REQ_FREE:  state_nxt = bpa_pkg::ST_FRD;
						default:            state_nxt = bpa_pkg::ST_POST;
					endcase
				end
			end
			bpa_pkg::ST_INIT: begin
				if (sts.idx_last) state_nxt = bpa_pkg::ST_POST;
			end
			bpa_pkg::ST_ARD: state_nxt = bpa_pkg::ST_ACHK;
			bpa_pkg::ST_ACHK: begin
				if (sts.word_nz || sts.scan_last) state_nxt = bpa_pkg::ST_POST;
				else state_nxt = bpa_pkg::ST_ARD;
			end
			bpa_pkg::ST_FRD:  state_nxt = bpa_pkg::ST_FCHK;
			bpa_pkg::ST_FCHK: state_nxt = bpa_pkg::ST_POST;
			bpa_pkg::ST_POST: begin
				if (!sts.out_busy) state_nxt = bpa_pkg::ST_IDLE;
			end
			default: state_nxt = bpa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			bpa_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take = 1'b1;
					case (req_type)
						bpa_pkg::REQ_INIT: cmd.clr_idx = 1'b1;
						bpa_pkg::REQ_ALLOC: begin
							if (sts.cnt_zero || sts.words_zero) cmd.res_fail = 1'b1;
							else cmd.clr_idx = 1'b1;
						end
						bpa_pkg::REQ_FREE: cmd.clr_idx = 1'b0;
						default: cmd.res_fail = 1'b1;
					endcase
				end
			end
			bpa_pkg::ST_INIT: begin
				cmd.init_wr = 1'b1;
				cmd.inc_idx = 1'b1;
				cmd.res_ok  = sts.idx_last;
			end
			bpa_pkg::ST_ARD: cmd.rd_scan = 1'b1;
			bpa_pkg::ST_ACHK: begin
				if (sts.word_nz) cmd.alloc_hit = 1'b1;
				else if (sts.scan_last) cmd.res_fail = 1'b1;
				else cmd.inc_idx = 1'b1;
			end
			bpa_pkg::ST_FRD: cmd.rd_free = 1'b1;
			bpa_pkg::ST_FCHK: begin
				if (sts.free_bad) cmd.res_fail = 1'b1;
				else cmd.free_set = 1'b1;
			end
			bpa_pkg::ST_POST: cmd.load_out = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: hw/rtl/bpa_dp.sv
`include "bitmap_page_allocator_defines.svh"

module bpa_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bpa_pkg::cmd_t               cmd,
	output bpa_pkg::sts_t               sts,
	input  logic [bpa_pkg::TW_W-1:0]    total_words,
	input  logic [bpa_pkg::OSP_W-1:0]   os_pages,
	input  logic [bpa_pkg::PAGE_W-1:0]  page_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bpa_pkg::PAGE_W-1:0]  page_out,
	output logic                        ok,
	output logic [bpa_pkg::FC_W-1:0]    free_count
);

	logic [bpa_pkg::WORD_BITS-1:0] mem [bpa_pkg::MAP_WORDS];
	logic [bpa_pkg::MAP_WORDS-1:0] vld_q;
	logic [bpa_pkg::WORD_BITS-1:0] rd_q;

	logic [bpa_pkg::WIDX_W-1:0]  idx_q;
	logic [bpa_pkg::PAGE_W-1:0]  page_q;
	logic [bpa_pkg::CNT_W-1:0]   free_pages_q;
	logic [bpa_pkg::PAGE_W-1:0]  res_page_q;
	logic                        res_ok_q;
	logic                        out_valid_q;
	logic [bpa_pkg::PAGE_W-1:0]  page_out_q;
	logic                        ok_q;
	logic [bpa_pkg::FC_W-1:0]    free_count_q;

	logic [31:0]                    words32;
	logic [bpa_pkg::WCNT_W-1:0]     words;
	logic [bpa_pkg::CNT_W-1:0]      pages;
	logic [bpa_pkg::CNT_W-1:0]      resv;
	logic [31:0]                    lo32;
	logic [bpa_pkg::WORD_BITS-1:0]  init_word;
	logic [31:0]                    fw32;
	logic [bpa_pkg::WIDX_W-1:0]     fw_idx;
	logic [bpa_pkg::BIT_W-1:0]      hit_bit;
	logic [bpa_pkg::WORD_BITS-1:0]  free_mask;
	logic [bpa_pkg::WIDX_W-1:0]     raddr;
	logic [bpa_pkg::WIDX_W-1:0]     waddr;
	logic [bpa_pkg::WORD_BITS-1:0]  wdata;
	logic                           wen;

	// words present, limited to the bitmap size
	always_comb begin
		words32 = (32'(total_words) > 32'(bpa_pkg::MAP_WORDS)) ?
			32'(bpa_pkg::MAP_WORDS) : 32'(total_words);
		words   = words32[bpa_pkg::WCNT_W-1:0];
		pages   = bpa_pkg::CNT_W'(words32 << bpa_pkg::BIT_W);
		resv    = (32'(os_pages) > 32'(pages)) ? pages : bpa_pkg::CNT_W'(os_pages);
		lo32    = 32'(idx_q) << bpa_pkg::BIT_W;
		if ((32'(idx_q) >= words32) || (lo32 + 32'(bpa_pkg::WORD_BITS) <= 32'(resv)))
			init_word = '0;
		else if (lo32 >= 32'(resv))
			init_word = bpa_pkg::ALL_FREE;
		else
			init_word = bpa_pkg::ALL_FREE << resv[bpa_pkg::BIT_W-1:0];
	end

	always_comb begin
		fw32      = 32'(page_q[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W]);
		fw_idx    = fw32[bpa_pkg::WIDX_W-1:0];
		hit_bit   = bpa_pkg::lsb_idx(rd_q);
		free_mask = bpa_pkg::ONE_BIT << page_q[bpa_pkg::BIT_W-1:0];
		raddr     = cmd.rd_free ? fw_idx : idx_q;
		waddr     = cmd.free_set ? fw_idx : idx_q;
		wen       = cmd.init_wr | cmd.alloc_hit | cmd.free_set;
		case (1'b1)
			cmd.init_wr:   wdata = init_word;
			cmd.alloc_hit: wdata = rd_q & ~(bpa_pkg::ONE_BIT << hit_bit);
			default:       wdata = rd_q | free_mask;
		endcase
	end

	always_comb begin
		sts.idx_last   = (idx_q == bpa_pkg::WIDX_W'(bpa_pkg::MAP_WORDS - 1));
		sts.scan_last  = (32'(idx_q) + 32'd1 >= words32);
		sts.cnt_zero   = (free_pages_q == '0);
		sts.words_zero = (words == '0);
		sts.word_nz    = (rd_q != '0);
		sts.free_bad   = (fw32 >= words32) || ((rd_q & free_mask) != '0);
		sts.out_busy   = out_valid_q && out_stall;
	end

	// bitmap words; an entry never written reads as zero
	always_ff @(posedge clk) begin
		if (wen) mem[waddr] <= wdata;
		if (cmd.rd_scan || cmd.rd_free) rd_q <= vld_q[raddr] ? mem[raddr] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wen) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			free_pages_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clr_idx) idx_q <= '0;
			else if (cmd.inc_idx) idx_q <= idx_q + 1'b1;
			if (cmd.init_wr && sts.idx_last) free_pages_q <= pages - resv;
			else if (cmd.alloc_hit) free_pages_q <= free_pages_q - 1'b1;
			else if (cmd.free_set) free_pages_q <= free_pages_q + 1'b1;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) page_q <= page_in;
		if (cmd.alloc_hit) begin
			res_page_q <= bpa_pkg::page_of(idx_q, hit_bit);
			res_ok_q   <= 1'b1;
		end else if (cmd.res_ok || cmd.free_set) begin
			res_page_q <= '0;
			res_ok_q   <= 1'b1;
		end else if (cmd.res_fail) begin
			res_page_q <= '0;
			res_ok_q   <= 1'b0;
		end
		if (cmd.load_out) begin
			page_out_q   <= res_page_q;
			ok_q         <= res_ok_q;
			free_count_q <= bpa_pkg::sat_fc(free_pages_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign page_out   = page_out_q;
	assign ok         = ok_q;
	assign free_count = free_count_q;

	`BPA_ASSERT_NOW(a_cnt_range, 1'b1, 32'(free_pages_q) <= 32'(bpa_pkg::CNT_MAX), "free count above page total")
	`BPA_ASSERT_NOW(a_hit_nonzero, cmd.alloc_hit, rd_q != '0, "allocation from an empty word")
	`BPA_ASSERT_NOW(a_no_overwrite, cmd.load_out, !(out_valid_q && out_stall), "pending result overwritten")
	`BPA_ASSERT_NXT(a_free_inc, cmd.free_set, free_pages_q == $past(free_pages_q) + 1'b1, "free did not raise count")
	`BPA_ASSERT_NOW(a_alloc_nonempty, cmd.alloc_hit, free_pages_q != '0, "allocation with zero free pages")

endmodule

FILE: hw/rtl/bitmap_page_allocator.sv
// Steps: init writes each word in turn; free reads a word, then checks it; allocate
// reads, then checks, each word scanned (registered RAM read, one word per read).
// Throughput: one request in flight; next request accepted once the result is queued
// in the output register, which may still be waiting on out_stall.
// Reset: free count 0, bitmap reads as all zero (per-word valid bits), total_words 16,
// os_pages 1. No clearing pass is needed.
module bitmap_page_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bpa_pkg::ADDR_W-1:0]  paddr,
	input  logic [bpa_pkg::DATA_W-1:0]  pwdata,
	output logic [bpa_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  req_type,
	input  logic [bpa_pkg::PAGE_W-1:0]  page_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bpa_pkg::PAGE_W-1:0]  page_out,
	output logic                        ok,
	output logic [bpa_pkg::FC_W-1:0]    free_count
);

	logic [bpa_pkg::TW_W-1:0]  total_words_q;
	logic [bpa_pkg::OSP_W-1:0] os_pages_q;
	logic                      wr_en;
	bpa_pkg::cmd_t             cmd;
	bpa_pkg::sts_t             sts;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_words_q <= bpa_pkg::TW_W'(bpa_pkg::TW_RESET);
			os_pages_q    <= bpa_pkg::OSP_W'(bpa_pkg::OSP_RESET);
		end else if (wr_en) begin
			case (paddr[2])
				bpa_pkg::REG_TOTAL_WORDS: total_words_q <= pwdata[bpa_pkg::TW_W-1:0];
				bpa_pkg::REG_OS_PAGES:    os_pages_q    <= pwdata[bpa_pkg::OSP_W-1:0];
				default:                  os_pages_q    <= os_pages_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			bpa_pkg::REG_TOTAL_WORDS: prdata = bpa_pkg::DATA_W'(total_words_q);
			bpa_pkg::REG_OS_PAGES:    prdata = bpa_pkg::DATA_W'(os_pages_q);
			default:                  prdata = '0;
		endcase
	end

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bpa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.total_words (total_words_q),
		.os_pages    (os_pages_q),
		.page_in     (page_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.page_out    (page_out),
		.ok          (ok),
		.free_count  (free_count)
	);

endmodule
